@@ src/euler_totient_sieve_assert.svh @@
// assertion macros used by the top-level rtl
`ifndef EULER_TOTIENT_SIEVE_ASSERT_SVH
`define EULER_TOTIENT_SIEVE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define ETS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define ETS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ets_pkg.sv @@
`default_nettype none

package ets_pkg;

  localparam int TABLE_SIZE = 65536;
  localparam int ADDR_W     = $clog2(TABLE_SIZE);
  localparam int IDX_W      = 16;
  localparam int VAL_W      = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [31:0] MAX_INDEX = 32'(TABLE_SIZE - 1);

  localparam logic CMD_BUILD = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // register index taken from paddr[2]
  localparam logic REG_HIGHEST_INDEX = 1'b0;

  localparam logic [IDX_W-1:0] HIGHEST_INDEX_RST = '1;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic             start;
    logic             command;
    logic [IDX_W-1:0] index;
    logic [IDX_W-1:0] limit;
    logic             built;
  } eng_cmd_t;

  typedef struct packed {
    logic             busy;
    logic             res_valid;
    logic [VAL_W-1:0] res_value;
    logic             res_ok;
    logic             built_set;
  } eng_sts_t;

  function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] x);
    logic [31:0] w;
    w = {{(32-IDX_W){1'b0}}, x};
    return w[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ src/ets_ram.sv @@
`default_nettype none

module ets_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ src/ets_alu.sv @@
`default_nettype none

module ets_alu (
  input  wire ets_pkg::alu_op_t op,
  input  wire logic [16:0]      a,
  input  wire logic [16:0]      b,
  output      logic [16:0]      y
);
  import ets_pkg::*;

  // single add/subtract shared by the sieve steps that need arithmetic
  always_comb begin
    case (op)
      ALU_ADD: y = a + b;
      ALU_SUB: y = a - b;
      default: y = a + b;
    endcase
  end

endmodule

`default_nettype wire

@@ src/ets_engine.sv @@
`default_nettype none

module ets_engine (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ets_pkg::eng_cmd_t cmd,
  input  wire logic              res_take,
  output      ets_pkg::eng_sts_t sts
);
  import ets_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_P_RD,
    ST_P_WAIT,
    ST_J_RD,
    ST_J_UPD,
    ST_Q_RD,
    ST_Q_DATA,
    ST_HOLD
  } state_t;

  state_t           state_r;
  logic [IDX_W-1:0] k_r;
  logic [IDX_W-1:0] i_r;
  logic [IDX_W:0]   j_r;
  logic [IDX_W-1:0] wa_r;
  logic [VAL_W-1:0] p_r;
  logic [IDX_W-1:0] lim_r;
  logic [VAL_W-1:0] res_value_r;
  logic             res_ok_r;
  logic             built_set_r;

  alu_op_t          alu_op;
  logic [16:0]      alu_a;
  logic [16:0]      alu_b;
  logic [16:0]      alu_y;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [VAL_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [VAL_W-1:0]  ram_rdata;

  logic [IDX_W:0]   i_inc;
  logic [IDX_W+1:0] i_inc_x2;
  logic             last_i;

  assign i_inc    = {1'b0, i_r} + 17'd1;
  assign i_inc_x2 = {i_inc, 1'b0};
  assign last_i   = i_inc_x2 > {2'b00, lim_r};

  ets_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  ets_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TABLE_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    alu_op    = ALU_ADD;
    alu_a     = '0;
    alu_b     = '0;
    ram_we    = 1'b0;
    ram_waddr = to_addr(k_r);
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = to_addr(k_r);
    case (state_r)
      ST_INIT: begin
        alu_op = ALU_SUB;
        alu_a  = {1'b0, k_r};
        alu_b  = 17'd1;
        ram_we = 1'b1;
        if (k_r == '0) begin
          ram_wdata = '0;
        end else if (k_r == 16'd1) begin
          ram_wdata = 16'd1;
        end else begin
          ram_wdata = alu_y[VAL_W-1:0];
        end
      end
      ST_P_RD: begin
        ram_re    = 1'b1;
        ram_raddr = to_addr(i_r);
      end
      ST_J_RD: begin
        alu_op    = ALU_ADD;
        alu_a     = j_r;
        alu_b     = {1'b0, i_r};
        ram_re    = 1'b1;
        ram_raddr = to_addr(j_r[IDX_W-1:0]);
      end
      ST_J_UPD: begin
        alu_op    = ALU_SUB;
        alu_a     = {1'b0, ram_rdata};
        alu_b     = {1'b0, p_r};
        ram_we    = 1'b1;
        ram_waddr = to_addr(wa_r);
        ram_wdata = alu_y[VAL_W-1:0];
      end
      ST_Q_RD: begin
        ram_re = 1'b1;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      built_set_r <= 1'b0;
    end else begin
      built_set_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (cmd.start) begin
            lim_r <= cmd.limit;
            if (cmd.command == CMD_BUILD) begin
              k_r     <= '0;
              state_r <= ST_INIT;
            end else if (cmd.built && (cmd.index <= cmd.limit)) begin
              k_r     <= cmd.index;
              state_r <= ST_Q_RD;
            end else begin
              res_value_r <= '0;
              res_ok_r    <= 1'b0;
              state_r     <= ST_HOLD;
            end
          end
        end
        ST_INIT: begin
          if (k_r == lim_r) begin
            i_r <= 16'd2;
            if (lim_r < 16'd4) begin
              res_value_r <= '0;
              res_ok_r    <= 1'b1;
              built_set_r <= 1'b1;
              state_r     <= ST_HOLD;
            end else begin
              state_r <= ST_P_RD;
            end
          end else begin
            k_r <= k_r + 16'd1;
          end
        end
        ST_P_RD: begin
          state_r <= ST_P_WAIT;
        end
        ST_P_WAIT: begin
          p_r     <= ram_rdata;
          j_r     <= {i_r, 1'b0};
          state_r <= ST_J_RD;
        end
        ST_J_RD: begin
          wa_r    <= j_r[IDX_W-1:0];
          j_r     <= alu_y;
          state_r <= ST_J_UPD;
        end
        ST_J_UPD: begin
          if (j_r > {1'b0, lim_r}) begin
            if (last_i) begin
              res_value_r <= '0;
              res_ok_r    <= 1'b1;
              built_set_r <= 1'b1;
              state_r     <= ST_HOLD;
            end else begin
              i_r     <= i_inc[IDX_W-1:0];
              state_r <= ST_P_RD;
            end
          end else begin
            state_r <= ST_J_RD;
          end
        end
        ST_Q_RD: begin
          state_r <= ST_Q_DATA;
        end
        ST_Q_DATA: begin
          res_value_r <= ram_rdata;
          res_ok_r    <= 1'b1;
          state_r     <= ST_HOLD;
        end
        ST_HOLD: begin
          if (res_take) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign sts.busy      = (state_r != ST_IDLE);
  assign sts.res_valid = (state_r == ST_HOLD);
  assign sts.res_value = res_value_r;
  assign sts.res_ok    = res_ok_r;
  assign sts.built_set = built_set_r;

endmodule

`default_nettype wire

@@ src/euler_totient_sieve.sv @@
// Euler totient table with build and query beats. A build beat (command 0) fills the table
// for indices 0..L, where L = min(highest_index, TABLE_SIZE-1), and answers value 0, ok 1;
// a query beat (command 1) answers the stored totient and ok 1, or value 0 and ok 0 when the
// index is above L or no build has finished since reset or the last write of highest_index.
// One beat is worked at a time and in_stall stays high until its result has moved into the
// output register. A query passes through the table read, the registered read data and the
// output load; a rejected query goes straight to the result hold and output load. A build
// first fills every entry 0..L with its starting value, then for each index i=2..L/2 fetches
// phi(i) and walks its multiples through the single table port pair and the shared
// add/subtract unit (read the multiple, write it back). A limit below 4 skips the multiples
// pass entirely.
// The table memory needs no clearing after reset.
`default_nettype none

`include "euler_totient_sieve_assert.svh"

module euler_totient_sieve (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input beats
  input  wire logic                              in_valid,
  output      logic                              in_stall,
  input  wire logic                              in_command,
  input  wire logic [ets_pkg::IDX_W-1:0]         in_query_index,
  // result beats
  output      logic                              out_valid,
  input  wire logic                              out_stall,
  output      logic [ets_pkg::VAL_W-1:0]         out_totient_value,
  output      logic                              out_ok,
  // configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [ets_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [ets_pkg::CFG_DATA_W-1:0]    pwdata,
  output      logic [ets_pkg::CFG_DATA_W-1:0]    prdata,
  output      logic                              pready
);
  import ets_pkg::*;

  logic [IDX_W-1:0] highest_index_r;
  logic             built_r;
  logic             out_valid_r;
  logic [VAL_W-1:0] out_value_r;
  logic             out_ok_r;

  logic             cfg_wr;
  logic             hi_wr;
  logic [IDX_W-1:0] limit;
  logic             in_acc;
  logic             res_take;

  eng_cmd_t         eng_cmd;
  eng_sts_t         eng_sts;

  // apb write completes in the access phase, pready is tied high
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign hi_wr  = cfg_wr && (paddr[2] == REG_HIGHEST_INDEX);

  always_comb begin
    if (paddr[2] == REG_HIGHEST_INDEX) begin
      prdata = {{(CFG_DATA_W-IDX_W){1'b0}}, highest_index_r};
    end else begin
      prdata = '0;
    end
  end

  // effective limit: register clipped to the table depth
  always_comb begin
    if ({{(32-IDX_W){1'b0}}, highest_index_r} > MAX_INDEX) begin
      limit = MAX_INDEX[IDX_W-1:0];
    end else begin
      limit = highest_index_r;
    end
  end

  // a beat is taken only while the sequencer is idle
  assign in_stall = eng_sts.busy;
  assign in_acc   = in_valid && !in_stall;

  assign eng_cmd.start   = in_acc;
  assign eng_cmd.command = in_command;
  assign eng_cmd.index   = in_query_index;
  assign eng_cmd.limit   = limit;
  assign eng_cmd.built   = built_r;

  // finished result moves on once the output register is free or draining
  assign res_take = eng_sts.res_valid && (!out_valid_r || !out_stall);

  ets_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (eng_cmd),
    .res_take (res_take),
    .sts      (eng_sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      highest_index_r <= HIGHEST_INDEX_RST;
      built_r         <= 1'b0;
    end else begin
      if (hi_wr) begin
        highest_index_r <= pwdata[IDX_W-1:0];
      end
      // a new limit invalidates the table, and wins over a finishing build
      if (hi_wr) begin
        built_r <= 1'b0;
      end else if (eng_sts.built_set) begin
        built_r <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (res_take) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_value_r <= eng_sts.res_value;
      out_ok_r    <= eng_sts.res_ok;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_totient_value = out_value_r;
  assign out_ok            = out_ok_r;

  // an accepted beat keeps the sequencer busy at least until its result is handed on
  `ETS_ASSERT_NXT(a_busy_after_accept, in_acc, in_stall, "sequencer idle right after accept")

  // a rejected query always carries a zero value
  `ETS_ASSERT_IMP(a_reject_zero, out_valid && !out_ok, out_totient_value == '0,
                  "rejected result with nonzero value")

  // writing the limit register drops the built flag
  `ETS_ASSERT_NXT(a_cfg_clears_built, hi_wr, !built_r,
                  "table still marked built after limit write")

  // result is handed over only while the output side can take it
  `ETS_ASSERT_IMP(a_take_when_free, res_take, !out_valid_r || !out_stall,
                  "result moved into a full output register")

endmodule

`default_nettype wire
